// ===== sv/nsx_pkg.sv =====
package nsx_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_HASH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_HASH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT_MODE  = 2'd3;
   localparam int CSR_DATA_W = 32;

   // Key schedule constants
   localparam logic [4:0] KEY_A_START     = 5'd0;
   localparam logic [3:0] KEY_B_START     = 4'd8;
   localparam logic [4:0] KEY_A_LAST      = 5'd15;
   localparam logic [4:0] KEY_B_WRAP_OVER = 5'd12;
   localparam logic [4:0] KEY_B_KEEP_MAX  = 5'd8;
   localparam logic [6:0] RUN_XOR_STEP    = 7'd2;
   localparam logic [4:0] KEY_A_OFFSET    = 5'd3;
   localparam logic [4:0] KEY_B_OFFSET    = 5'd2;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One byte job handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key_a;
      logic [7:0] key_b;
      logic [6:0] run_xor;
      logic       swap;
      logic       decrypt;
   } nsx_job_type;

   // Push side of the queue
   typedef struct packed {
      logic        valid;
      nsx_job_type job;
   } nsx_push_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic        valid;
      nsx_job_type job;
   } nsx_head_type;

   // Pick byte sel of a 32-bit hash, little-endian
   function automatic logic [7:0] key_byte(input logic [31:0] hash, input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0: b = hash[7:0];
         2'd1: b = hash[15:8];
         2'd2: b = hash[23:16];
         2'd3: b = hash[31:24];
         default: b = hash[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
      return {v[3:0], v[7:4]};
   endfunction

   // 7-bit value mod 7: fold octal digits (8 == 1 mod 7)
   function automatic logic [2:0] mod7(input logic [6:0] x);
      logic [3:0] s1;
      logic [3:0] s2;
      logic [3:0] r;
      s1 = {3'b0, x[6]} + {1'b0, x[5:3]} + {1'b0, x[2:0]};
      s2 = {3'b0, s1[3]} + {1'b0, s1[2:0]};
      r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
      return r[2:0];
   endfunction

   // 5-bit value mod 3: fold base-4 digits (4 == 1 mod 3)
   function automatic logic [1:0] mod3(input logic [4:0] y);
      logic [3:0] s1;
      logic [2:0] s2;
      logic [2:0] r;
      s1 = {1'b0, y[4:2]} + {2'b0, y[1:0]};
      s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
      r  = (s2 >= 3'd3) ? s2 - 3'd3 : s2;
      return r[1:0];
   endfunction

   // 7-bit value mod 12 = 4 * ((x >> 2) mod 3) + x[1:0]
   function automatic logic [3:0] mod12(input logic [6:0] x);
      return {mod3(x[6:2]), x[1:0]};
   endfunction

endpackage

// ===== sv/nsx_if.sv =====
// Input byte channel
interface nsx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       start_of_buffer;

   modport source (output valid, output data_in, output start_of_buffer, input ready);
   modport sink   (input valid, input data_in, input start_of_buffer, output ready);
endinterface

// Result byte channel
interface nsx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

// ===== sv/nsx_front.sv =====
module nsx_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [nsx_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nsx_pkg::CSR_DATA_W-1:0]     csr_write_data,
   nsx_req_if.sink                            req,
   input  logic                               queue_full,
   output nsx_pkg::nsx_push_type              push
);
   import nsx_pkg::*;

   logic [31:0] name_hash_ff;
   logic [31:0] length_hash_ff;
   logic [31:0] buffer_length_ff;
   logic        decrypt_ff;

   logic [4:0]  key_a_idx_ff, key_a_idx_in;
   logic [3:0]  key_b_idx_ff, key_b_idx_in;
   logic        swap_ff, swap_in;
   logic [6:0]  run_xor_ff, run_xor_in;

   logic        accept;
   logic [4:0]  ka_cur;
   logic [3:0]  kb_cur;
   logic        sw_cur;
   logic [6:0]  rx_cur;
   logic [4:0]  ka_inc;
   logic [4:0]  kb_inc;
   logic [4:0]  kb_next;
   logic [6:0]  rx_step;
   logic [2:0]  rx_mod7;
   logic [3:0]  rx_mod12;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         name_hash_ff     <= '0;
         length_hash_ff   <= '0;
         buffer_length_ff <= '0;
         decrypt_ff       <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NAME_HASH:     name_hash_ff     <= csr_write_data;
            CSR_LENGTH_HASH:   length_hash_ff   <= csr_write_data;
            CSR_BUFFER_LENGTH: buffer_length_ff <= csr_write_data;
            CSR_DECRYPT_MODE:  decrypt_ff       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Apply the start flag before this byte
   always_comb begin
      if (req.start_of_buffer) begin
         ka_cur = KEY_A_START;
         kb_cur = KEY_B_START;
         sw_cur = 1'b0;
         rx_cur = buffer_length_ff[8:2];
      end else begin
         ka_cur = key_a_idx_ff;
         kb_cur = key_b_idx_ff;
         sw_cur = swap_ff;
         rx_cur = run_xor_ff;
      end
   end

   // Advance indices, swap flag and running xor
   assign ka_inc   = ka_cur + 5'd1;
   assign kb_inc   = {1'b0, kb_cur} + 5'd1;
   assign rx_step  = rx_cur + RUN_XOR_STEP;
   assign rx_mod7  = mod7(rx_step);
   assign rx_mod12 = mod12(rx_step);

   always_comb begin
      key_a_idx_in = ka_inc;
      kb_next      = kb_inc;
      swap_in      = sw_cur;
      run_xor_in   = rx_cur;
      if (ka_inc <= KEY_A_LAST) begin
         if (kb_inc > KEY_B_WRAP_OVER) begin
            kb_next = '0;
            swap_in = !sw_cur;
         end
      end else if (kb_inc <= KEY_B_KEEP_MAX) begin
         key_a_idx_in = '0;
         swap_in      = !sw_cur;
      end else begin
         run_xor_in = rx_step;
         if (sw_cur) begin
            swap_in      = 1'b0;
            key_a_idx_in = {2'b0, rx_mod7};
            kb_next      = {1'b0, rx_mod12} + KEY_B_OFFSET;
         end else begin
            swap_in      = 1'b1;
            key_a_idx_in = {1'b0, rx_mod12} + KEY_A_OFFSET;
            kb_next      = {2'b0, rx_mod7};
         end
      end
      key_b_idx_in = kb_next[3:0];
   end

   // Hold key state; advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_idx_ff <= KEY_A_START;
         key_b_idx_ff <= KEY_B_START;
         swap_ff      <= 1'b0;
         run_xor_ff   <= '0;
      end else if (accept) begin
         key_a_idx_ff <= key_a_idx_in;
         key_b_idx_ff <= key_b_idx_in;
         swap_ff      <= swap_in;
         run_xor_ff   <= run_xor_in;
      end
   end

   // Build the job for the back end
   assign push.valid       = accept;
   assign push.job.data    = req.data_in;
   assign push.job.key_a   = key_byte(name_hash_ff, ka_cur[1:0]);
   assign push.job.key_b   = key_byte(length_hash_ff, kb_cur[1:0]);
   assign push.job.run_xor = rx_cur;
   assign push.job.swap    = sw_cur;
   assign push.job.decrypt = decrypt_ff;

   // Stored key A index never leaves 0..15, key B index never exceeds 13
   a_key_a_range: assert property (@(posedge clock) disable iff (reset)
      !key_a_idx_ff[4])
      else $error("key A index out of range");
   a_key_b_range: assert property (@(posedge clock) disable iff (reset)
      key_b_idx_ff <= 4'd13)
      else $error("key B index out of range");

endmodule

// ===== sv/nsx_queue.sv =====
module nsx_queue #(
   parameter int DEPTH = nsx_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nsx_pkg::nsx_push_type push,
   output logic                  full,
   output nsx_pkg::nsx_head_type head,
   input  logic                  pop
);
   import nsx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nsx_job_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the last slot
   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");
   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

// ===== sv/nsx_back.sv =====
module nsx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  nsx_pkg::nsx_head_type head,
   output logic                  pop,
   nsx_rsp_if.source             rsp
);
   import nsx_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [7:0] pre_mask;
   logic [7:0] post_mask;
   logic [7:0] mixed;
   logic [7:0] swapped;

   // Take the head when the output register is free or drains this cycle
   assign pop = head.valid && (!rsp_valid_ff || rsp.ready);

   // Mirror the key order for decrypt
   always_comb begin
      if (head.job.decrypt) begin
         pre_mask  = {1'b0, head.job.run_xor} ^ head.job.key_b;
         post_mask = head.job.key_a;
      end else begin
         pre_mask  = head.job.key_a;
         post_mask = {1'b0, head.job.run_xor} ^ head.job.key_b;
      end
      mixed       = head.job.data ^ pre_mask;
      swapped     = head.job.swap ? swap_nibbles(mixed) : mixed;
      rsp_data_in = swapped ^ post_mask;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result byte
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = rsp_data_ff;

endmodule

// ===== sv/nibble_swap_xor_byte_cipher.sv =====
// An accepted input byte is written into the job queue, and its result is loaded into
// the output register at the queue head when that register is free or draining.
// Throughput: one byte per cycle while the queue is not full.
// The job queue holds QUEUE_DEPTH bytes, so input keeps flowing while a result waits.
// Reset (synchronous, active high) clears the configuration registers to 0, key A
// index to 0, key B index to 8, swap flag and running xor to 0, and empties the queue.
module nibble_swap_xor_byte_cipher #(
   parameter int QUEUE_DEPTH = nsx_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [nsx_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nsx_pkg::CSR_DATA_W-1:0]     csr_write_data,
   nsx_req_if.sink                            req_chan,
   nsx_rsp_if.source                          rsp_chan
);
   import nsx_pkg::*;

   nsx_push_type push;
   nsx_head_type head;
   logic         queue_full;
   logic         pop;

   nsx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req            (req_chan),
      .queue_full     (queue_full),
      .push           (push)
   );

   nsx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   nsx_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ===== verif/nibble_swap_xor_byte_cipher_tb.sv =====
`timescale 1ns / 100ps

module nibble_swap_xor_byte_cipher_tb;
   import nsx_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BYTES = 2000;
   localparam int HOLD_AT_BEAT = 800;
   localparam int HOLD_CYCLES  = 300;

   // Cipher state and key registers, mirrored byte by byte
   class cipher_scoreboard;
      logic [31:0] name_hash;
      logic [31:0] length_hash;
      logic [31:0] buffer_length;
      logic        decrypt_mode;
      logic [4:0]  key_a_idx;
      logic [3:0]  key_b_idx;
      logic        swap;
      logic [6:0]  run_xor;
      logic [7:0]  expected_bytes[$];
      int unsigned errors;
      int unsigned bytes_in;
      int unsigned bytes_checked;
      int unsigned starts;
      int unsigned reseeds;

      function new();
         name_hash     = '0;
         length_hash   = '0;
         buffer_length = '0;
         decrypt_mode  = 1'b0;
         key_a_idx     = KEY_A_START;
         key_b_idx     = KEY_B_START;
         swap          = 1'b0;
         run_xor       = '0;
         errors        = 0;
         bytes_in      = 0;
         bytes_checked = 0;
         starts        = 0;
         reseeds       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_NAME_HASH:     name_hash = val;
            CSR_LENGTH_HASH:   length_hash = val;
            CSR_BUFFER_LENGTH: buffer_length = val;
            CSR_DECRYPT_MODE:  decrypt_mode = val[0];
            default: ;
         endcase
      endfunction

      // Transform one accepted byte and advance the key schedule
      function void cipher_byte(logic [7:0] data, logic start);
         logic [7:0] key_a;
         logic [7:0] key_b;
         logic [7:0] b;
         logic [4:0] a_next;
         logic [4:0] b_next;
         if (start) begin
            key_a_idx = KEY_A_START;
            key_b_idx = KEY_B_START;
            swap      = 1'b0;
            run_xor   = buffer_length[8:2];
            starts++;
         end
         key_a = name_hash[{key_a_idx[1:0], 3'b000} +: 8];
         key_b = length_hash[{key_b_idx[1:0], 3'b000} +: 8];

         b = data;
         if (decrypt_mode) begin
            b = b ^ {1'b0, run_xor} ^ key_b;
            if (swap) b = {b[3:0], b[7:4]};
            b = b ^ key_a;
         end else begin
            b = b ^ key_a;
            if (swap) b = {b[3:0], b[7:4]};
            b = b ^ {1'b0, run_xor} ^ key_b;
         end
         expected_bytes.push_back(b);
         bytes_in++;

         // step both indices, then wrap or reseed
         a_next = key_a_idx + 5'd1;
         b_next = {1'b0, key_b_idx} + 5'd1;
         if (a_next <= KEY_A_LAST) begin
            if (b_next > KEY_B_WRAP_OVER) begin
               b_next = '0;
               swap   = ~swap;
            end
         end else if (b_next <= KEY_B_KEEP_MAX) begin
            a_next = '0;
            swap   = ~swap;
         end else begin
            run_xor = run_xor + RUN_XOR_STEP;
            if (swap) begin
               swap   = 1'b0;
               a_next = 5'(run_xor % 7);
               b_next = 5'(run_xor % 12) + KEY_B_OFFSET;
            end else begin
               swap   = 1'b1;
               a_next = 5'(run_xor % 12) + KEY_A_OFFSET;
               b_next = 5'(run_xor % 7);
            end
            reseeds++;
         end
         key_a_idx = a_next;
         key_b_idx = b_next[3:0];
      endfunction

      function void check_result_byte(logic [7:0] actual);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: result byte %02h with no byte pending", $time, actual);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want !== actual) begin
               $display("%0t: data_out mismatch, expected %02h actual %02h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int unsigned            gap_pct = 33;
   int unsigned            settings = 0;

   cipher_scoreboard sb = new();

   nsx_req_if req_bus ();
   nsx_rsp_if rsp_bus ();

   nibble_swap_xor_byte_cipher u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus)
   );

   always #5 clock = ~clock;

   // Write one register; the caller drops the enable after the last one
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic load_keys(input logic [31:0] nh, input logic [31:0] lh,
                            input logic [31:0] bl, input logic dm);
      write_csr(CSR_NAME_HASH, nh);
      write_csr(CSR_LENGTH_HASH, lh);
      write_csr(CSR_BUFFER_LENGTH, bl);
      write_csr(CSR_DECRYPT_MODE, {31'b0, dm});
      csr_write_en <= 1'b0;
      settings++;
   endtask

   // Offer one beat after a random gap and hold it until accepted
   task automatic send_byte(input logic [7:0] data, input logic start);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data_in         <= data;
      req_bus.start_of_buffer <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.cipher_byte(data, start);
   endtask

   // Drop valid and wait for every pending byte to come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(600));
         default: return $urandom;
      endcase
   endfunction

   // Stimulus
   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned burst;
      csr_write_en            <= 1'b0;
      csr_index               <= '0;
      csr_write_data          <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.data_in         <= '0;
      req_bus.start_of_buffer <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no start flag yet: bytes run from the reset state
      load_keys(32'hDEAD_BEEF, 32'h1234_5678, 32'h0000_01FC, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b0);
      drain_results();

      // all-ones keys and length, encrypt order
      load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      drain_results();

      // zero keys, decrypt order
      load_keys(32'h0, 32'h0, 32'h0, 1'b1);
      send_byte(8'h12, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hC3, 1'b0);
      drain_results();

      // run past a three-byte buffer, then restart mid-stream
      load_keys($urandom, $urandom, 32'd3, 1'b1);
      for (int i = 0; i < 7; i++) send_byte(8'($urandom), i == 0 || i == 5);
      drain_results();

      // random buffers under random keys; a few continue the old stream
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_BYTES) begin
         gap_pct = (phase >= 4 && phase < 8) ? 0 : 33;
         load_keys(pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)));
         burst = $urandom_range(120, 20);
         for (int i = 0; i < burst; i++) begin
            send_byte(8'($urandom),
                      (i == 0 && $urandom_range(9) != 0) || $urandom_range(49) == 0);
         end
         drain_results();
         sent += burst;
         phase++;
      end
      gap_pct = 33;

      repeat (4) @(posedge clock);
      $display("Sent %0d bytes under %0d register settings, %0d buffer starts",
               sb.bytes_in, settings, sb.starts);
      $display("Checked %0d result bytes across %0d key reseeds",
               sb.bytes_checked, sb.reseeds);
      if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Result side: check each beat, stall at random, one long hold-off
   initial begin
      int unsigned beats;
      bit          held;
      beats = 0;
      held  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result_byte(rsp_bus.data_out);
            beats++;
         end
         if (!held && beats >= HOLD_AT_BEAT && req_bus.valid) begin
            // hold off while the sender keeps pushing, so the queue fills
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= !reset && (gap_pct == 0 || $urandom_range(99) >= gap_pct);
      end
   end

   // Watchdog: end the run if no beat moves for too long
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/nsx_pkg.sv
sv/nsx_if.sv
sv/nsx_front.sv
sv/nsx_queue.sv
sv/nsx_back.sv
sv/nibble_swap_xor_byte_cipher.sv
verif/nibble_swap_xor_byte_cipher_tb.sv
